### design/mca_pkg.sv
// Package for the must-cache age update block: sizes, age type, operation codes, control struct.
package mca_pkg;

  // Sizes
  localparam int MAX_BLOCKS = 64;
  localparam int MAX_ASSOC  = 16;
  localparam int BLK_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
  localparam int ASSOC_W    = 5;
  localparam int SET_W      = 10;
  localparam int AGE_W      = 6;
  localparam int OP_W       = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  typedef logic signed [AGE_W-1:0] age_t;

  // Special ages and reset values
  localparam age_t AGE_BOT = -6'sd1;
  localparam logic [ASSOC_W-1:0] RST_ASSOC = 5'd4;
  localparam logic [SET_W-1:0]   RST_SET   = '0;
  localparam logic [CNT_W-1:0]   RST_COUNT = CNT_W'(MAX_BLOCKS);

  // Operation codes
  localparam logic [OP_W-1:0] OP_NONE     = 3'd0;
  localparam logic [OP_W-1:0] OP_FETCH    = 3'd1;
  localparam logic [OP_W-1:0] OP_PREFETCH = 3'd2;
  localparam logic [OP_W-1:0] OP_JOIN     = 3'd3;
  localparam logic [OP_W-1:0] OP_WRITE    = 3'd4;
  localparam logic [OP_W-1:0] OP_SET_TOP  = 3'd5;
  localparam logic [OP_W-1:0] OP_SET_BOT  = 3'd6;
  localparam logic [OP_W-1:0] OP_COMPARE  = 3'd7;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ASSOC = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SET   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd2;

  // Update control from the top level to the age lanes
  typedef struct packed {
    logic             upd;       // commit next state this cycle
    logic             fetch_en;  // age the younger blocks
    logic             elem_en;   // write new_age into the addressed block
    logic [BLK_W-1:0] blk;
    age_t             new_age;
  } mca_ctl_t;

endpackage

### design/mca_lanes.sv
// Age registers, one lane per memory block, with parallel fetch aging and bottom detection.
module mca_lanes (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  mca_pkg::mca_ctl_t         ctl_i,
  input  logic [mca_pkg::CNT_W-1:0] active_n_i,
  output mca_pkg::age_t             ref_age_o,
  output logic                      all_bot_cur_o,
  output logic                      all_bot_nxt_o
);

  mca_pkg::age_t ages_q [mca_pkg::MAX_BLOCKS];
  mca_pkg::age_t ages_d [mca_pkg::MAX_BLOCKS];

  // Read the addressed block
  assign ref_age_o = ages_q[ctl_i.blk];

  // Compute next ages and bottom flags over active lanes
  always_comb begin
    all_bot_cur_o = 1'b1;
    all_bot_nxt_o = 1'b1;
    for (int i = 0; i < mca_pkg::MAX_BLOCKS; i++) begin
      ages_d[i] = ages_q[i];
      if (ctl_i.elem_en && (ctl_i.blk == mca_pkg::BLK_W'(i))) begin
        ages_d[i] = ctl_i.new_age;
      end else if (ctl_i.fetch_en && (mca_pkg::CNT_W'(i) < active_n_i) &&
                   (ages_q[i] < ref_age_o) && (ages_q[i] != mca_pkg::AGE_BOT)) begin
        ages_d[i] = ages_q[i] + mca_pkg::age_t'(1);
      end
      if (mca_pkg::CNT_W'(i) < active_n_i) begin
        if (ages_q[i] != mca_pkg::AGE_BOT) all_bot_cur_o = 1'b0;
        if (ages_d[i] != mca_pkg::AGE_BOT) all_bot_nxt_o = 1'b0;
      end
    end
  end

  // Commit on advance; reset every block to top
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mca_pkg::MAX_BLOCKS; i++) begin
        ages_q[i] <= mca_pkg::age_t'({1'b0, mca_pkg::RST_ASSOC});
      end
    end else if (ctl_i.upd) begin
      for (int i = 0; i < mca_pkg::MAX_BLOCKS; i++) begin
        ages_q[i] <= ages_d[i];
      end
    end
  end

endmodule

### design/must_cache_age_update.sv
// Top level of the must-cache LRU age update block.
//
//  channel  direction  handshake                    payload
//  in       input      in_valid_i / in_stall_o      operation, access_set, block_index, other_age
//  out      output     out_valid_o / out_stall_i    element_age, state_is_bottom, element_matches
//  cfg      input      cfg_we_i                     cfg_addr_i, cfg_data_i
//
// One transaction per cycle while the result side does not stall; the input register holds the accepted transaction.
// The input register feeds one pass of lane logic (64 parallel age comparators)
// that commits the block ages and loads the result register in the same edge.
// Reset sets every age to top (4), associativity 4, set 0, block count 64.
// A stalled result holds the input register, which stalls the input side.
module must_cache_age_update (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mca_pkg::CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [mca_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [mca_pkg::OP_W-1:0]      operation_i,
  input  logic [mca_pkg::SET_W-1:0]     access_set_i,
  input  logic [mca_pkg::BLK_W-1:0]     block_index_i,
  input  logic signed [mca_pkg::AGE_W-1:0] other_age_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [mca_pkg::AGE_W-1:0] element_age_o,
  output logic                          state_is_bottom_o,
  output logic                          element_matches_o
);

  // Configuration registers
  logic [mca_pkg::ASSOC_W-1:0] assoc_q;
  logic [mca_pkg::SET_W-1:0]   tset_q;
  logic [mca_pkg::CNT_W-1:0]   count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      assoc_q <= mca_pkg::RST_ASSOC;
      tset_q  <= mca_pkg::RST_SET;
      count_q <= mca_pkg::RST_COUNT;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        mca_pkg::CFG_ASSOC: assoc_q <= cfg_data_i[mca_pkg::ASSOC_W-1:0];
        mca_pkg::CFG_SET:   tset_q  <= cfg_data_i[mca_pkg::SET_W-1:0];
        mca_pkg::CFG_COUNT: count_q <= cfg_data_i[mca_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate associativity and block count
  mca_pkg::age_t               top_age;
  logic [mca_pkg::CNT_W-1:0]   active_n;

  always_comb begin
    if (assoc_q == '0) begin
      top_age = mca_pkg::age_t'(1);
    end else if (assoc_q > mca_pkg::ASSOC_W'(mca_pkg::MAX_ASSOC)) begin
      top_age = mca_pkg::age_t'(mca_pkg::MAX_ASSOC);
    end else begin
      top_age = mca_pkg::age_t'({1'b0, assoc_q});
    end
    if (count_q > mca_pkg::CNT_W'(mca_pkg::MAX_BLOCKS)) begin
      active_n = mca_pkg::CNT_W'(mca_pkg::MAX_BLOCKS);
    end else begin
      active_n = count_q;
    end
  end

  // Input register
  logic                        s1_valid_q;
  logic [mca_pkg::OP_W-1:0]    op_q;
  logic [mca_pkg::SET_W-1:0]   aset_q;
  logic [mca_pkg::BLK_W-1:0]   blk_q;
  mca_pkg::age_t               other_q;
  logic                        s1_adv;
  logic                        in_acc;

  assign s1_adv     = s1_valid_q && (!out_valid_o || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q    <= operation_i;
      aset_q  <= access_set_i;
      blk_q   <= block_index_i;
      other_q <= other_age_i;
    end
  end

  // Per-item decode and new age of the addressed block
  mca_pkg::mca_ctl_t ctl;
  mca_pkg::age_t     ref_age;
  mca_pkg::age_t     clamped;
  mca_pkg::age_t     new_age;
  logic              all_bot_cur;
  logic              all_bot_nxt;
  logic              in_range;
  logic              fetch_en;
  logic              match;

  assign in_range = {1'b0, blk_q} < active_n;
  assign fetch_en = in_range && (aset_q == tset_q) && !all_bot_cur &&
                    ((op_q == mca_pkg::OP_FETCH) || (op_q == mca_pkg::OP_PREFETCH));
  assign match    = in_range && (op_q == mca_pkg::OP_COMPARE) && (ref_age == other_q);

  always_comb begin
    if (other_q < mca_pkg::AGE_BOT) begin
      clamped = mca_pkg::AGE_BOT;
    end else if (other_q > top_age) begin
      clamped = top_age;
    end else begin
      clamped = other_q;
    end
    case (op_q)
      mca_pkg::OP_FETCH:    new_age = fetch_en ? '0 : ref_age;
      mca_pkg::OP_PREFETCH: new_age = (fetch_en && (ref_age == mca_pkg::AGE_BOT)) ?
                                      '0 : ref_age;
      mca_pkg::OP_JOIN:     new_age = (clamped > ref_age) ? clamped : ref_age;
      mca_pkg::OP_WRITE:    new_age = clamped;
      mca_pkg::OP_SET_TOP:  new_age = top_age;
      mca_pkg::OP_SET_BOT:  new_age = mca_pkg::AGE_BOT;
      default:              new_age = ref_age;
    endcase
  end

  always_comb begin
    ctl.upd      = s1_adv;
    ctl.fetch_en = fetch_en;
    ctl.elem_en  = in_range;
    ctl.blk      = blk_q;
    ctl.new_age  = new_age;
  end

  mca_lanes u_lanes (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .active_n_i    (active_n),
    .ref_age_o     (ref_age),
    .all_bot_cur_o (all_bot_cur),
    .all_bot_nxt_o (all_bot_nxt)
  );

  // Result register
  logic          out_valid_q;
  mca_pkg::age_t eage_q;
  logic          bot_q;
  logic          match_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      eage_q  <= in_range ? new_age : mca_pkg::AGE_BOT;
      bot_q   <= all_bot_nxt;
      match_q <= match;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign element_age_o     = eage_q;
  assign state_is_bottom_o = bot_q;
  assign element_matches_o = match_q;

  // Checks
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with empty input register");

  a_adv_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_o)
    else $error("advanced transaction produced no result");

  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!s1_adv && !cfg_we_i) |=> $stable(all_bot_cur))
    else $error("age state changed without a transaction");

  a_match_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && match) |-> (op_q == mca_pkg::OP_COMPARE))
    else $error("match flagged on a non-compare transaction");

endmodule

### sim/must_cache_age_update_test.sv
// Self-checking testbench for the must-cache LRU age update block: directed table plus random phases.
`timescale 1ns / 1ps

module must_cache_age_update_test;

  localparam int NUM_ROWS    = 36;
  localparam int NUM_PHASES  = 8;
  localparam int PHASE_ITEMS = 210;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PRINT_LIMIT = 50;

  // Register index with no register behind it
  localparam logic [mca_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    mca_pkg::age_t age;
    logic          bottom;
    logic          match;
  } result_t;

  typedef struct packed {
    row_kind_e                      kind;
    logic [mca_pkg::CFG_IDX_W-1:0]  reg_idx;
    logic [mca_pkg::CFG_DATA_W-1:0] reg_val;
    logic [mca_pkg::OP_W-1:0]       op;
    logic [mca_pkg::SET_W-1:0]      aset;
    logic [mca_pkg::BLK_W-1:0]      blk;
    mca_pkg::age_t                  other;
    logic                           typed;
    mca_pkg::age_t                  exp_age;
    logic                           exp_bottom;
    logic                           exp_match;
  } dir_row_t;

  // kind, reg, value, op, access set, block, age operand, typed, age, bottom, match
  dir_row_t directed_steps [NUM_ROWS] = '{
    '{ROW_ITEM, mca_pkg::CFG_ASSOC, 0,    mca_pkg::OP_NONE,     0,    0,  0,   1, 4,  0, 0},
    '{ROW_ITEM, mca_pkg::CFG_ASSOC, 0,    mca_pkg::OP_COMPARE,  0,    63, 4,   1, 4,  0, 1},
    '{ROW_ITEM, mca_pkg::CFG_ASSOC, 0,    mca_pkg::OP_COMPARE,  0,    0,  -32, 1, 4,  0, 0},
    '{ROW_ITEM, mca_pkg::CFG_ASSOC, 0,    mca_pkg::OP_FETCH,    0,    0,  0,   1, 0,  0, 0},
    '{ROW_ITEM, mca_pkg::CFG_ASSOC, 0,    mca_pkg::OP_FETCH,    5,    1,  0,   1, 4,  0, 0},
    '{ROW_ITEM, mca_pkg::CFG_ASSOC, 0,    mca_pkg::OP_FETCH,    0,    1,  0,   1, 0,  0, 0},
    '{ROW_ITEM, mca_pkg::CFG_ASSOC, 0,    mca_pkg::OP_PREFETCH, 0,    2,  0,   0, 0,  0, 0},
    '{ROW_ITEM, mca_pkg::CFG_ASSOC, 0,    mca_pkg::OP_JOIN,     0,    3,  31,  0, 0,  0, 0},
    '{ROW_ITEM, mca_pkg::CFG_ASSOC, 0,    mca_pkg::OP_WRITE,    0,    3,  2,   1, 2,  0, 0},
    '{ROW_ITEM, mca_pkg::CFG_ASSOC, 0,    mca_pkg::OP_WRITE,    0,    4,  -32, 1, -1, 0, 0},
    '{ROW_ITEM, mca_pkg::CFG_ASSOC, 0,    mca_pkg::OP_JOIN,     0,    4,  1,   0, 0,  0, 0},
    '{ROW_ITEM, mca_pkg::CFG_ASSOC, 0,    mca_pkg::OP_SET_TOP,  0,    5,  0,   1, 4,  0, 0},
    '{ROW_ITEM, mca_pkg::CFG_ASSOC, 0,    mca_pkg::OP_SET_BOT,  0,    5,  0,   1, -1, 0, 0},
    '{ROW_ITEM, mca_pkg::CFG_ASSOC, 0,    mca_pkg::OP_COMPARE,  0,    5,  -1,  1, -1, 0, 1},
    '{ROW_ITEM, mca_pkg::CFG_ASSOC, 0,    mca_pkg::OP_PREFETCH, 0,    5,  0,   0, 0,  0, 0},
    '{ROW_ITEM, mca_pkg::CFG_ASSOC, 0,    mca_pkg::OP_COMPARE,  0,    7,  31,  0, 0,  0, 0},
    '{ROW_ITEM, mca_pkg::CFG_ASSOC, 0,    mca_pkg::OP_WRITE,    0,    63, 16,  0, 0,  0, 0},
    '{ROW_CFG,  mca_pkg::CFG_COUNT, 3,    mca_pkg::OP_NONE,     0,    0,  0,   0, 0,  0, 0},
    '{ROW_ITEM, mca_pkg::CFG_ASSOC, 0,    mca_pkg::OP_WRITE,    0,    5,  0,   1, -1, 0, 0},
    '{ROW_ITEM, mca_pkg::CFG_ASSOC, 0,    mca_pkg::OP_COMPARE,  0,    63, -1,  1, -1, 0, 0},
    '{ROW_ITEM, mca_pkg::CFG_ASSOC, 0,    mca_pkg::OP_SET_BOT,  0,    0,  0,   0, 0,  0, 0},
    '{ROW_ITEM, mca_pkg::CFG_ASSOC, 0,    mca_pkg::OP_SET_BOT,  0,    1,  0,   0, 0,  0, 0},
    '{ROW_ITEM, mca_pkg::CFG_ASSOC, 0,    mca_pkg::OP_SET_BOT,  0,    2,  0,   1, -1, 1, 0},
    '{ROW_ITEM, mca_pkg::CFG_ASSOC, 0,    mca_pkg::OP_FETCH,    0,    0,  0,   1, -1, 1, 0},
    '{ROW_ITEM, mca_pkg::CFG_ASSOC, 0,    mca_pkg::OP_PREFETCH, 0,    1,  0,   1, -1, 1, 0},
    '{ROW_CFG,  mca_pkg::CFG_COUNT, 0,    mca_pkg::OP_NONE,     0,    0,  0,   0, 0,  0, 0},
    '{ROW_ITEM, mca_pkg::CFG_ASSOC, 0,    mca_pkg::OP_NONE,     0,    0,  0,   1, -1, 1, 0},
    '{ROW_CFG,  mca_pkg::CFG_COUNT, 127,  mca_pkg::OP_NONE,     0,    0,  0,   0, 0,  0, 0},
    '{ROW_CFG,  mca_pkg::CFG_ASSOC, 0,    mca_pkg::OP_NONE,     0,    0,  0,   0, 0,  0, 0},
    '{ROW_ITEM, mca_pkg::CFG_ASSOC, 0,    mca_pkg::OP_SET_TOP,  0,    10, 0,   1, 1,  0, 0},
    '{ROW_CFG,  mca_pkg::CFG_ASSOC, 31,   mca_pkg::OP_NONE,     0,    0,  0,   0, 0,  0, 0},
    '{ROW_ITEM, mca_pkg::CFG_ASSOC, 0,    mca_pkg::OP_WRITE,    0,    11, 31,  1, 16, 0, 0},
    '{ROW_CFG,  mca_pkg::CFG_SET,   1023, mca_pkg::OP_NONE,     0,    0,  0,   0, 0,  0, 0},
    '{ROW_ITEM, mca_pkg::CFG_ASSOC, 0,    mca_pkg::OP_FETCH,    1023, 12, 0,   1, 0,  0, 0},
    '{ROW_CFG,  CFG_SPARE,          1023, mca_pkg::OP_NONE,     0,    0,  0,   0, 0,  0, 0},
    '{ROW_ITEM, mca_pkg::CFG_ASSOC, 0,    mca_pkg::OP_COMPARE,  1023, 11, 16,  1, 16, 0, 1}
  };

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                           cfg_we      = 1'b0;
  logic [mca_pkg::CFG_IDX_W-1:0]  cfg_addr    = '0;
  logic [mca_pkg::CFG_DATA_W-1:0] cfg_data    = '0;
  logic                           in_valid    = 1'b0;
  logic                           in_stall;
  logic [mca_pkg::OP_W-1:0]       operation   = '0;
  logic [mca_pkg::SET_W-1:0]      access_set  = '0;
  logic [mca_pkg::BLK_W-1:0]      block_index = '0;
  mca_pkg::age_t                  other_age   = '0;
  logic                           out_valid;
  logic                           out_stall   = 1'b0;
  mca_pkg::age_t                  element_age;
  logic                           state_is_bottom;
  logic                           element_matches;

  // Shadow copy of the block state and registers
  mca_pkg::age_t                shadow_ages [mca_pkg::MAX_BLOCKS];
  logic [mca_pkg::ASSOC_W-1:0]  shadow_assoc = mca_pkg::RST_ASSOC;
  logic [mca_pkg::SET_W-1:0]    shadow_set   = mca_pkg::RST_SET;
  logic [mca_pkg::CNT_W-1:0]    shadow_count = mca_pkg::RST_COUNT;

  result_t expected_results [$];
  bit      no_idle        = 1'b0;
  int      mismatch_count = 0;
  int      results_seen   = 0;
  int      items_sent     = 0;
  int      reg_writes     = 0;
  int      compare_hits   = 0;
  int      cycle_count    = 0;

  must_cache_age_update uut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_addr_i       (cfg_addr),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .operation_i      (operation),
    .access_set_i     (access_set),
    .block_index_i    (block_index),
    .other_age_i      (other_age),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .element_age_o    (element_age),
    .state_is_bottom_o(state_is_bottom),
    .element_matches_o(element_matches)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Stall the result side at random, except during the steady phase
  always @(posedge clk) begin
    out_stall <= !no_idle && ($urandom_range(99) < 30);
  end

  function automatic int top_age();
    if (shadow_assoc == 0) return 1;
    if (shadow_assoc > mca_pkg::MAX_ASSOC) return mca_pkg::MAX_ASSOC;
    return int'(shadow_assoc);
  endfunction

  function automatic int active_blocks();
    if (shadow_count > mca_pkg::MAX_BLOCKS) return mca_pkg::MAX_BLOCKS;
    return int'(shadow_count);
  endfunction

  function automatic bit all_bottom(input int n);
    for (int i = 0; i < n; i++)
      if (shadow_ages[i] != mca_pkg::AGE_BOT) return 1'b0;
    return 1'b1;
  endfunction

  // Apply one access to the shadow ages and return the result it produces
  function automatic result_t update_ages(input logic [mca_pkg::OP_W-1:0] op,
                                          input logic [mca_pkg::SET_W-1:0] aset,
                                          input logic [mca_pkg::BLK_W-1:0] blk,
                                          input mca_pkg::age_t other);
    result_t       res;
    mca_pkg::age_t prior_ages [mca_pkg::MAX_BLOCKS];
    int            n;
    int            b;
    int            v;
    int            pivot;
    n = active_blocks();
    b = int'(blk);
    res.match = 1'b0;
    // clamp the operand for join and write
    v = int'(other);
    if (v < -1) v = -1;
    if (v > top_age()) v = top_age();
    if (b < n) begin
      case (op)
        mca_pkg::OP_FETCH, mca_pkg::OP_PREFETCH: begin
          if (aset == shadow_set && !all_bottom(n)) begin
            prior_ages = shadow_ages;
            pivot = int'(shadow_ages[b]);
            for (int i = 0; i < n; i++)
              if (shadow_ages[i] < pivot && shadow_ages[i] != mca_pkg::AGE_BOT)
                shadow_ages[i] = mca_pkg::age_t'(int'(shadow_ages[i]) + 1);
            shadow_ages[b] = '0;
            // prefetch keeps the older (larger) age of each block
            if (op == mca_pkg::OP_PREFETCH)
              for (int i = 0; i < n; i++)
                if (prior_ages[i] > shadow_ages[i]) shadow_ages[i] = prior_ages[i];
          end
        end
        mca_pkg::OP_JOIN: begin
          if (v > shadow_ages[b]) shadow_ages[b] = mca_pkg::age_t'(v);
        end
        mca_pkg::OP_WRITE:   shadow_ages[b] = mca_pkg::age_t'(v);
        mca_pkg::OP_SET_TOP: shadow_ages[b] = mca_pkg::age_t'(top_age());
        mca_pkg::OP_SET_BOT: shadow_ages[b] = mca_pkg::AGE_BOT;
        mca_pkg::OP_COMPARE: res.match = (shadow_ages[b] == other);
        default: ;
      endcase
      res.age = shadow_ages[b];
    end else begin
      res.age = mca_pkg::AGE_BOT;
    end
    res.bottom = all_bottom(n);
    if (res.match) compare_hits++;
    return res;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("[%0t] mismatch on %s: got %0d, expected %0d (result %0d)",
               $realtime, field, got, want, results_seen);
  endtask

  // Offer one transaction and hold it until accepted
  task automatic issue_access(input logic [mca_pkg::OP_W-1:0] op,
                              input logic [mca_pkg::SET_W-1:0] aset,
                              input logic [mca_pkg::BLK_W-1:0] blk, input mca_pkg::age_t other,
                              input bit typed, input result_t typed_res);
    result_t res;
    in_valid    <= 1'b1;
    operation   <= op;
    access_set  <= aset;
    block_index <= blk;
    other_age   <= other;
    do @(posedge clk); while (in_stall);
    res = update_ages(op, aset, blk, other);
    expected_results.push_back(typed ? typed_res : res);
    items_sent++;
  endtask

  // Drop valid now and then, except during the steady phase
  task automatic sender_pause();
    if (!no_idle && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(2, 1)) @(posedge clk);
    end
  endtask

  // Drain all results, then write one register
  task automatic write_register(input logic [mca_pkg::CFG_IDX_W-1:0] idx,
                                input logic [mca_pkg::CFG_DATA_W-1:0] val);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      mca_pkg::CFG_ASSOC: shadow_assoc = val[mca_pkg::ASSOC_W-1:0];
      mca_pkg::CFG_SET:   shadow_set   = val[mca_pkg::SET_W-1:0];
      mca_pkg::CFG_COUNT: shadow_count = val[mca_pkg::CNT_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // Check each accepted result against the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", int'(element_age), 0);
      end else begin
        want = expected_results.pop_front();
        if (element_age !== want.age)
          report_mismatch("element_age", int'(element_age), int'(want.age));
        if (state_is_bottom !== want.bottom)
          report_mismatch("state_is_bottom", int'(state_is_bottom), int'(want.bottom));
        if (element_matches !== want.match)
          report_mismatch("element_matches", int'(element_matches), int'(want.match));
      end
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles with %0d results pending", cycle_count,
             expected_results.size());
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    result_t                     typed_res;
    dir_row_t                    row;
    logic [mca_pkg::OP_W-1:0]    op;
    logic [mca_pkg::SET_W-1:0]   aset;
    logic [mca_pkg::BLK_W-1:0]   blk;
    mca_pkg::age_t               other;
    logic [mca_pkg::ASSOC_W-1:0] assoc_v;
    logic [mca_pkg::CNT_W-1:0]   count_v;
    logic [mca_pkg::SET_W-1:0]   set_v;
    logic [31:0]                 junk;
    int                          n;
    int                          top;
    int                          pick;
    int                          counted;

    foreach (shadow_ages[i]) shadow_ages[i] = mca_pkg::age_t'(mca_pkg::RST_ASSOC);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: extremes, every operation, special cases
    for (int r = 0; r < NUM_ROWS; r++) begin
      row = directed_steps[r];
      if (row.kind == ROW_CFG) begin
        write_register(row.reg_idx, row.reg_val);
      end else begin
        typed_res.age    = row.exp_age;
        typed_res.bottom = row.exp_bottom;
        typed_res.match  = row.exp_match;
        issue_access(row.op, row.aset, row.blk, row.other, row.typed, typed_res);
        sender_pause();
      end
    end

    // Random phases, each under its own register setting
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin assoc_v = 5'd1;  count_v = 7'd2;   end
        1: begin assoc_v = 5'd16; count_v = 7'd64;  end
        2: begin assoc_v = 5'd31; count_v = 7'd127; end
        3: begin assoc_v = 5'd0;  count_v = 7'd1;   end
        4: begin assoc_v = 5'd3;  count_v = 7'd6;   end
        5: begin
          assoc_v = mca_pkg::ASSOC_W'($urandom_range(16, 1));
          count_v = mca_pkg::CNT_W'($urandom_range(64, 1));
        end
        6: begin
          assoc_v = mca_pkg::ASSOC_W'($urandom_range(31));
          count_v = mca_pkg::CNT_W'($urandom_range(12, 2));
        end
        default: begin assoc_v = 5'd8; count_v = 7'd16; end
      endcase
      if (phase == 1) set_v = 10'd1023;
      else set_v = $urandom_range(1) ? mca_pkg::SET_W'($urandom_range(1023)) : '0;
      // unused upper data bits carry noise
      junk = $urandom;
      write_register(mca_pkg::CFG_ASSOC, {junk[4:0], assoc_v});
      write_register(mca_pkg::CFG_COUNT, {junk[7:5], count_v});
      write_register(mca_pkg::CFG_SET, set_v);
      no_idle = (phase == 1);

      counted = 0;
      while (counted < PHASE_ITEMS) begin
        n    = active_blocks();
        top  = top_age();
        pick = $urandom_range(99);
        if (pick < 30)      op = mca_pkg::OP_FETCH;
        else if (pick < 45) op = mca_pkg::OP_PREFETCH;
        else if (pick < 55) op = mca_pkg::OP_COMPARE;
        else if (pick < 63) op = mca_pkg::OP_JOIN;
        else if (pick < 73) op = mca_pkg::OP_WRITE;
        else if (pick < 78) op = mca_pkg::OP_SET_TOP;
        else if (pick < 82) op = mca_pkg::OP_SET_BOT;
        else if (pick < 85) op = mca_pkg::OP_NONE;
        else                op = mca_pkg::OP_W'($urandom_range(7));
        aset = ($urandom_range(9) == 0) ? mca_pkg::SET_W'($urandom_range(1023)) : shadow_set;
        if (n > 0 && $urandom_range(19) != 0) blk = mca_pkg::BLK_W'($urandom_range(n - 1));
        else blk = mca_pkg::BLK_W'($urandom_range(63));
        if ($urandom_range(9) == 0) other = mca_pkg::age_t'($urandom);
        else other = mca_pkg::age_t'(int'($urandom_range(top + 1)) - 1);
        if (op == mca_pkg::OP_COMPARE && $urandom_range(1)) other = shadow_ages[blk];
        if (op != mca_pkg::OP_NONE && int'(blk) < n) counted++;
        issue_access(op, aset, blk, other, 1'b0, typed_res);
        sender_pause();
      end
    end

    // Drain and let the pipeline settle
    no_idle = 1'b0;
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Covered %0d transactions over %0d register writes, all eight operations,",
             items_sent, reg_writes);
    $display("out-of-range blocks, foreign sets and all-bottom states; %0d results, %0d hits",
             results_seen, compare_hits);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
